// File: rtl/lld_pkg.sv
// shared types and constants of the least loaded dispatcher
`default_nettype none

package lld_pkg;

    // request modes
    localparam logic [1:0] MODE_DISPATCH = 2'd0;
    localparam logic [1:0] MODE_START    = 2'd1;
    localparam logic [1:0] MODE_END      = 2'd2;

    // configuration register indexes
    localparam logic CFG_COUNTING = 1'b0;
    localparam logic CFG_ACTIVE   = 1'b1;

    // least load at or above this value triggers a rebase pass
    localparam logic [31:0] REBASE_LIMIT = 32'h00ff_ffff;

    // operations of the shared load unit
    typedef enum logic [1:0] {
        ALU_LT  = 2'd0,
        ALU_SUB = 2'd1,
        ALU_INC = 2'd2
    } alu_op_t;

endpackage

`default_nettype wire

// File: rtl/least_loaded_dispatcher_top.sv
// least loaded dispatcher: load table, sequencer and result register
//
// usage
//   request channel (in_valid/in_ready, mode, loader_index): a dispatch request
//   picks the available participating loader with the least load, lowest index
//   on a tie; start and end session requests clear one loader's load and set or
//   clear its available flag.
//   result channel (out_valid/out_ready, granted, chosen_loader, none_available):
//   one result per request, in request order.
//   configuration: cfg_we writes cfg_data into register cfg_index (0 counting_mode,
//   1 active_loaders); the user must write only while the block is idle (unchecked).
// sequence, n = min(active_loaders, LOADERS)
//   session or unused mode: accept leads straight to the done state
//   dispatch: scan of the first n loaders; a granted dispatch in counting mode then
//   increments the chosen load, after a rebase pass (read then write per loader)
//   scan: one loader per cycle via the shared load unit and the single ram read port
// reset clears all loads (per entry valid bits), marks every loader available,
// and sets counting_mode to 0 and active_loaders to 1.
// a stalled receiver holds the result register; a new request is still
// accepted and its result waits in the sequencer until the register frees.
`default_nettype none

module least_loaded_dispatcher_top #(
    parameter int LOADERS    = 8,
    parameter int LOAD_WIDTH = 25
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] mode,
    input  wire logic [2:0] loader_index,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            granted,
    output logic [2:0]      chosen_loader,
    output logic            none_available,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [3:0] cfg_data
);

    localparam int IDX_W = (LOADERS > 1) ? $clog2(LOADERS) : 1;
    localparam int CNT_W = $clog2(LOADERS + 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b000_0001,
        ST_SCAN   = 7'b000_0010,
        ST_REB_RD = 7'b000_0100,
        ST_REB_WR = 7'b000_1000,
        ST_INC_RD = 7'b001_0000,
        ST_INC_WR = 7'b010_0000,
        ST_DONE   = 7'b100_0000
    } state_t;

    state_t state_reg, state_next;

    logic                  counting_reg;
    logic [3:0]            active_reg;
    logic [CNT_W-1:0]      part_n;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      cnt_idx;
    logic [IDX_W-1:0]      best_reg, best_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  pend_avail_reg, pend_avail_next;
    logic                  found_reg, found_next;
    logic [LOAD_WIDTH-1:0] least_reg, least_next;
    logic                  res_granted_reg, res_granted_next;
    logic                  res_none_reg, res_none_next;

    logic [LOADERS-1:0]    avail_reg, avail_next;
    logic [LOADERS-1:0]    lvalid_reg, lvalid_next;
    logic                  rd_valid_reg;

    logic                  out_valid_reg;
    logic                  granted_reg;
    logic [2:0]            chosen_reg;
    logic                  none_reg;
    logic                  out_load;

    logic                  in_accept;
    logic                  sess_ok;
    logic [IDX_W-1:0]      sess_addr;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [LOAD_WIDTH-1:0] ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [LOAD_WIDTH-1:0] ram_q;
    logic [LOAD_WIDTH-1:0] load_q;

    lld_pkg::alu_op_t      alu_op;
    logic [LOAD_WIDTH-1:0] alu_a, alu_b, alu_y;
    logic                  alu_lt;

    // participating loaders, saturated to the table depth
    assign part_n = (int'(active_reg) > LOADERS) ? CNT_W'(LOADERS) : CNT_W'(active_reg);

    assign cnt_idx   = cnt_reg[IDX_W-1:0];
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign sess_ok   = ({29'd0, loader_index} < 32'(LOADERS));
    assign sess_addr = IDX_W'(loader_index);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // entries never written read as zero load
    assign load_q = rd_valid_reg ? ram_q : '0;

    lld_ram #(
        .WIDTH (LOAD_WIDTH),
        .DEPTH (LOADERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    lld_alu #(
        .WIDTH (LOAD_WIDTH)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y),
        .lt (alu_lt)
    );

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        best_next        = best_reg;
        pend_idx_next    = pend_idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_avail_next  = pend_avail_reg;
        found_next       = found_reg;
        least_next       = least_reg;
        res_granted_next = res_granted_reg;
        res_none_next    = res_none_reg;
        avail_next       = avail_reg;
        lvalid_next      = lvalid_reg;
        ram_we           = 1'b0;
        ram_waddr        = cnt_idx;
        ram_wdata        = alu_y;
        ram_raddr        = cnt_idx;
        alu_op           = lld_pkg::ALU_LT;
        alu_a            = load_q;
        alu_b            = least_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cnt_next         = '0;
                    best_next        = '0;
                    pend_valid_next  = 1'b0;
                    found_next       = 1'b0;
                    res_granted_next = 1'b0;
                    res_none_next    = 1'b0;
                    state_next       = ST_DONE;
                    if (mode == lld_pkg::MODE_DISPATCH)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if ((mode == lld_pkg::MODE_START || mode == lld_pkg::MODE_END)
                             && sess_ok)
                    begin
                        ram_we                = 1'b1;
                        ram_waddr             = sess_addr;
                        ram_wdata             = '0;
                        avail_next[sess_addr] = (mode == lld_pkg::MODE_START);
                    end
                end
            end

            ST_SCAN:
            begin
                // compare the entry read last cycle
                if (pend_valid_reg)
                begin
                    if (pend_avail_reg && (!found_reg || alu_lt))
                    begin
                        found_next = 1'b1;
                        best_next  = pend_idx_reg;
                        least_next = load_q;
                    end
                end
                else
                begin
                    alu_a = least_reg;
                    alu_b = LOAD_WIDTH'(lld_pkg::REBASE_LIMIT);
                end
                // issue the next read or close the scan
                if (cnt_reg < part_n)
                begin
                    pend_valid_next = 1'b1;
                    pend_idx_next   = cnt_idx;
                    pend_avail_next = avail_reg[cnt_idx];
                    cnt_next        = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    pend_valid_next = 1'b0;
                    if (!pend_valid_reg)
                    begin
                        cnt_next = '0;
                        if (!found_reg)
                        begin
                            res_none_next = 1'b1;
                            state_next    = ST_DONE;
                        end
                        else
                        begin
                            res_granted_next = 1'b1;
                            if (!counting_reg)
                            begin
                                state_next = ST_DONE;
                            end
                            else if (!alu_lt)
                            begin
                                state_next = ST_REB_RD;
                            end
                            else
                            begin
                                state_next = ST_INC_RD;
                            end
                        end
                    end
                end
            end

            ST_REB_RD:
            begin
                if (cnt_reg == part_n)
                begin
                    state_next = ST_INC_RD;
                end
                else
                begin
                    state_next = ST_REB_WR;
                end
            end

            ST_REB_WR:
            begin
                // subtract the least load from an available entry
                alu_op = lld_pkg::ALU_SUB;
                if (avail_reg[cnt_idx])
                begin
                    ram_we = 1'b1;
                end
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = ST_REB_RD;
            end

            ST_INC_RD:
            begin
                ram_raddr  = best_reg;
                state_next = ST_INC_WR;
            end

            ST_INC_WR:
            begin
                alu_op     = lld_pkg::ALU_INC;
                ram_we     = 1'b1;
                ram_waddr  = best_reg;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ram_we)
        begin
            lvalid_next[ram_waddr] = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            counting_reg   <= 1'b0;
            active_reg     <= 4'd1;
            avail_reg      <= '1;
            lvalid_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            avail_reg      <= avail_next;
            lvalid_reg     <= lvalid_next;
            rd_valid_reg   <= lvalid_reg[ram_raddr];
            pend_valid_reg <= pend_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lld_pkg::CFG_COUNTING: counting_reg <= cfg_data[0];
                    lld_pkg::CFG_ACTIVE:   active_reg   <= cfg_data;
                    default:               active_reg   <= active_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg         <= cnt_next;
        best_reg        <= best_next;
        pend_idx_reg    <= pend_idx_next;
        pend_avail_reg  <= pend_avail_next;
        found_reg       <= found_next;
        least_reg       <= least_next;
        res_granted_reg <= res_granted_next;
        res_none_reg    <= res_none_next;
        if (out_load)
        begin
            granted_reg <= res_granted_reg;
            chosen_reg  <= res_granted_reg ? 3'(best_reg) : 3'd0;
            none_reg    <= res_none_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted        = granted_reg;
    assign chosen_loader  = chosen_reg;
    assign none_available = none_reg;

endmodule

`default_nettype wire

// File: rtl/lld_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none

module lld_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/lld_alu.sv
// shared load unit: compare, subtract and saturating increment
`default_nettype none

module lld_alu #(
    parameter int WIDTH = 25
) (
    input  wire lld_pkg::alu_op_t   op,
    input  wire logic [WIDTH-1:0]   a,
    input  wire logic [WIDTH-1:0]   b,
    output logic      [WIDTH-1:0]   y,
    output logic                    lt
);

    // one operation per cycle, chosen by the sequencer
    always_comb
    begin
        lt = (a < b);
        unique case (op)
            lld_pkg::ALU_LT:  y = '0;
            lld_pkg::ALU_SUB: y = a - b;
            lld_pkg::ALU_INC: y = (&a) ? a : a + WIDTH'(1);
            default:          y = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/lld_checker.sv
// port level checks of the least loaded dispatcher and their bind
`default_nettype none

module lld_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       granted,
    input wire logic [2:0] chosen_loader,
    input wire logic       none_available
);

    // a result waits until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // grant and no-loader flags exclude each other
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(granted && none_available))
        else $error("granted and none_available both set");

    // a result without grant names loader zero
    a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> chosen_loader == 3'd0)
        else $error("chosen_loader set without grant");

    // one request at a time: busy right after a request is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

endmodule

bind least_loaded_dispatcher_top lld_checker u_lld_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .granted        (granted),
    .chosen_loader  (chosen_loader),
    .none_available (none_available)
);

`default_nettype wire
